// ----- design/lpg_pkg.sv -----
// Shared types and constants for the line pixel generator.
package lpg_pkg;

  // Coordinate width; request and pixel structs follow from it.
  localparam int COORD_BITS = 6;
  localparam int COLOR_BITS = 16;
  // Error term: signed, two bits wider than a coordinate.
  localparam int ERR_BITS   = COORD_BITS + 2;
  // Depth of the job queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  // One line request.
  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t pixel_color;
  } line_req_t;

  // One output pixel.
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t color_out;
    logic   last_pixel;
  } pixel_t;

  // Prepared line job handed from front to back.
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t xe;
    coord_t ye;
    coord_t dx;
    coord_t dy;
    logic   sx_neg;
    logic   sy_neg;
    err_t   err;
    color_t color;
  } line_job_t;

endpackage

// ----- design/lpg_front.sv -----
// Front end: accepts line requests and computes deltas, steps and starting error.
module lpg_front import lpg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  line_req_t in_req,
  output logic      job_valid,
  input  logic      job_ready,
  output line_job_t job
);

  logic      job_vld_r, job_vld_nxt;
  line_job_t job_r, job_nxt;
  coord_t    dx, dy;

  // Absolute deltas and step directions
  always_comb begin
    dx = (in_req.end_x > in_req.start_x) ? in_req.end_x - in_req.start_x
                                         : in_req.start_x - in_req.end_x;
    dy = (in_req.end_y > in_req.start_y) ? in_req.end_y - in_req.start_y
                                         : in_req.start_y - in_req.end_y;
    job_nxt.x      = in_req.start_x;
    job_nxt.y      = in_req.start_y;
    job_nxt.xe     = in_req.end_x;
    job_nxt.ye     = in_req.end_y;
    job_nxt.dx     = dx;
    job_nxt.dy     = dy;
    job_nxt.sx_neg = !(in_req.start_x < in_req.end_x);
    job_nxt.sy_neg = !(in_req.start_y < in_req.end_y);
    job_nxt.color  = in_req.pixel_color;
    // starting error: dx/2 or -(dy/2)
    if (dx > dy) begin
      job_nxt.err = signed'({2'b00, (dx >> 1)});
    end else begin
      job_nxt.err = -signed'({2'b00, (dy >> 1)});
    end
  end

  assign in_ready  = !job_vld_r || job_ready;
  assign job_valid = job_vld_r;
  assign job       = job_r;

  // Holding register toward the queue
  always_comb begin
    job_vld_nxt = job_vld_r;
    if (in_valid && in_ready) begin
      job_vld_nxt = 1'b1;
    end else if (job_ready) begin
      job_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
    end else begin
      job_vld_r <= job_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      job_r <= job_nxt;
    end
  end

endmodule

// ----- design/lpg_queue.sv -----
// Short register queue of prepared line jobs.
module lpg_queue import lpg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  line_job_t wr_job,
  output logic      rd_valid,
  input  logic      rd_ready,
  output line_job_t rd_job
);

  localparam int PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntBits = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(QUEUE_DEPTH - 1);
  localparam logic [CntBits-1:0] FullCnt = CntBits'(QUEUE_DEPTH);

  line_job_t            slot_r [QUEUE_DEPTH];
  logic [PtrBits-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CntBits-1:0]   cnt_r, cnt_nxt;
  logic                 push, pop;

  assign wr_ready = (cnt_r != FullCnt);
  assign rd_valid = (cnt_r != '0);
  assign rd_job   = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

// ----- design/lpg_back.sv -----
// Back end: steps the Bresenham error loop and emits one pixel per cycle unless the output stalls.
module lpg_back import lpg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  output logic      job_ready,
  input  line_job_t job,
  output logic      out_valid,
  input  logic      out_ready,
  output pixel_t    out_pixel
);

  localparam coord_t GuardCnt = '1;

  logic      busy_r, busy_nxt;
  line_job_t cur_r, cur_nxt;
  coord_t    n_r, n_nxt;
  logic      out_vld_r, out_vld_nxt;
  pixel_t    out_r, out_nxt;
  logic      emit, done, step_x, step_y;
  err_t      dx_e, dy_e;

  assign job_ready = !busy_r;
  assign emit      = busy_r && (!out_vld_r || out_ready);
  assign out_valid = out_vld_r;
  assign out_pixel = out_r;

  assign dx_e   = signed'({2'b00, cur_r.dx});
  assign dy_e   = signed'({2'b00, cur_r.dy});
  assign done   = ((cur_r.x == cur_r.xe) && (cur_r.y == cur_r.ye)) || (n_r == GuardCnt);
  assign step_x = cur_r.err > -dx_e;
  assign step_y = cur_r.err < dy_e;

  // Step the current line, or load the next job when idle
  always_comb begin
    busy_nxt = busy_r;
    cur_nxt  = cur_r;
    n_nxt    = n_r;
    if (!busy_r) begin
      if (job_valid) begin
        busy_nxt = 1'b1;
        cur_nxt  = job;
        n_nxt    = '0;
      end
    end else if (emit) begin
      if (done) begin
        busy_nxt = 1'b0;
      end else begin
        n_nxt = n_r + 1'b1;
        cur_nxt.err = cur_r.err - (step_x ? dy_e : '0) + (step_y ? dx_e : '0);
        if (step_x) begin
          cur_nxt.x = cur_r.sx_neg ? cur_r.x - 1'b1 : cur_r.x + 1'b1;
        end
        if (step_y) begin
          cur_nxt.y = cur_r.sy_neg ? cur_r.y - 1'b1 : cur_r.y + 1'b1;
        end
      end
    end
  end

  // Output register
  always_comb begin
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    if (emit) begin
      out_vld_nxt          = 1'b1;
      out_nxt.pixel_x      = cur_r.x;
      out_nxt.pixel_y      = cur_r.y;
      out_nxt.color_out    = cur_r.color;
      out_nxt.last_pixel   = done;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    n_r   <= n_nxt;
    out_r <= out_nxt;
  end

endmodule

// ----- design/line_pixel_generator.sv -----
// Top level of the Bresenham line pixel generator.
//
//  channel  direction  handshake             payload
//  in_      input      in_valid / in_ready   in_req    (line_req_t)
//  out_     output     out_valid / out_ready out_pixel (pixel_t)
//
// A line of N = max(dx, dy) + 1 pixels emits one pixel per cycle from the
// back-end stepper while the output is not stalled, and the next job is loaded
// after the last pixel. Requests pass the front register and the queue first.
// Reset (rst_n low, synchronous) empties the front register, queue and stepper.
// Output stalls hold the pixel register and freeze the stepper; the queue keeps
// taking requests until it fills.
module line_pixel_generator import lpg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  line_req_t in_req,
  output logic      out_valid,
  input  logic      out_ready,
  output pixel_t    out_pixel
);

  logic      fr_valid, fr_ready, bk_valid, bk_ready;
  line_job_t fr_job, bk_job;

  // Request setup
  lpg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .job_valid (fr_valid),
    .job_ready (fr_ready),
    .job       (fr_job)
  );

  // Job queue
  lpg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_job   (fr_job),
    .rd_valid (bk_valid),
    .rd_ready (bk_ready),
    .rd_job   (bk_job)
  );

  // Pixel stepper
  lpg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (bk_valid),
    .job_ready (bk_ready),
    .job       (bk_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pixel (out_pixel)
  );

endmodule

// ----- design/lpg_checker.sv -----
// Port-level assertions for the line pixel generator, bound to the top level.
module lpg_checker import lpg_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input line_req_t in_req,
  input logic      out_valid,
  input logic      out_ready,
  input pixel_t    out_pixel
);

  logic out_acc;
  assign out_acc = out_valid && out_ready;

  // Waiting request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_req))
    else $error("input request changed while waiting");

  // Stalled pixel holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel))
    else $error("output pixel changed while stalled");

  // No pixel right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A non-final pixel is followed at once by the next one, same color
  a_next_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_pixel.last_pixel |=> out_valid &&
      out_pixel.color_out == $past(out_pixel.color_out))
    else $error("line pixel missing or color changed");

  // Consecutive pixels of a line are 8-connected neighbors and differ
  a_neighbor: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_pixel.last_pixel |=>
      (out_pixel.pixel_x == $past(out_pixel.pixel_x) ||
       out_pixel.pixel_x == $past(out_pixel.pixel_x) + coord_t'(1) ||
       out_pixel.pixel_x == $past(out_pixel.pixel_x) - coord_t'(1)) &&
      (out_pixel.pixel_y == $past(out_pixel.pixel_y) ||
       out_pixel.pixel_y == $past(out_pixel.pixel_y) + coord_t'(1) ||
       out_pixel.pixel_y == $past(out_pixel.pixel_y) - coord_t'(1)) &&
      (out_pixel.pixel_x != $past(out_pixel.pixel_x) ||
       out_pixel.pixel_y != $past(out_pixel.pixel_y)))
    else $error("line pixels not adjacent");

endmodule

bind line_pixel_generator lpg_checker u_lpg_checker (.*);

// ----- tb/lpg_pixel_check.sv -----
`timescale 1ns / 1ps
// Pixel checker for the line pixel generator: traces each accepted line and checks every pixel.
module lpg_pixel_check import lpg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  line_req_t in_req,
  input  logic      out_valid,
  input  logic      out_ready,
  input  pixel_t    out_pixel,
  output int        fail_count,
  output int        pending_pixels
);

  localparam int MAX_PIXELS = 1 << COORD_BITS;

  // Pixels still owed by the block, oldest first
  pixel_t expected_pixels[$];
  int     pixel_index;

  initial begin
    fail_count     = 0;
    pending_pixels = 0;
    pixel_index    = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] pixel %0d: %s", $realtime, pixel_index, what);
    fail_count++;
  endtask

  // Walk the integer Bresenham line of one request, queueing every pixel
  task automatic trace_line(input line_req_t req);
    int     x, y, xe, ye, dx, dy, sx, sy, err, e2, n;
    bit     done;
    pixel_t p;
    x  = req.start_x;
    y  = req.start_y;
    xe = req.end_x;
    ye = req.end_y;
    dx = (xe > x) ? xe - x : x - xe;
    dy = (ye > y) ? ye - y : y - ye;
    sx = (x < xe) ? 1 : -1;
    sy = (y < ye) ? 1 : -1;
    // starting error leans toward the major axis
    err = (dx > dy) ? dx / 2 : -(dy / 2);
    n = 0;
    forever begin
      done = (x == xe && y == ye) || (n == MAX_PIXELS - 1);
      p.pixel_x    = coord_t'(x);
      p.pixel_y    = coord_t'(y);
      p.color_out  = req.pixel_color;
      p.last_pixel = done;
      expected_pixels.push_back(p);
      n++;
      if (done) break;
      e2 = err;
      if (e2 > -dx) begin
        err -= dy;
        x += sx;
      end
      if (e2 < dy) begin
        err += dx;
        y += sy;
      end
    end
  endtask

  // Compare one delivered pixel against the oldest one owed
  task automatic check_pixel(input pixel_t got);
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      report_mismatch($sformatf("unexpected pixel x=%0d y=%0d", got.pixel_x, got.pixel_y));
    end else begin
      want = expected_pixels.pop_front();
      if (got.pixel_x !== want.pixel_x)
        report_mismatch($sformatf("pixel_x got %0d, want %0d", got.pixel_x, want.pixel_x));
      if (got.pixel_y !== want.pixel_y)
        report_mismatch($sformatf("pixel_y got %0d, want %0d", got.pixel_y, want.pixel_y));
      if (got.color_out !== want.color_out)
        report_mismatch($sformatf("color_out got %h, want %h", got.color_out, want.color_out));
      if (got.last_pixel !== want.last_pixel)
        report_mismatch($sformatf("last_pixel got %b, want %b", got.last_pixel,
                                  want.last_pixel));
    end
    pixel_index++;
  endtask

  // Watch both channels on every edge out of reset
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_pixel(out_pixel);
      if (in_valid && in_ready) trace_line(in_req);
      pending_pixels <= expected_pixels.size();
    end
  end

endmodule

// ----- tb/line_pixel_generator_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the line pixel generator: clock, reset, line requests, pixel sink and verdict.
module line_pixel_generator_tb;
  import lpg_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_LINES = 200;
  localparam int DRAIN_CYCLES = 80;
  localparam int LONG_HOLD    = 500;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  line_req_t in_req;
  logic      out_valid;
  logic      out_ready;
  pixel_t    out_pixel;

  int fail_count;
  int pending_pixels;
  int cycle_count = 0;
  int sunk_pixels = 0;
  bit steady = 1'b0;

  line_pixel_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pixel (out_pixel)
  );

  lpg_pixel_check pixel_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req         (in_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel      (out_pixel),
    .fail_count     (fail_count),
    .pending_pixels (pending_pixels)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("line_pixel_generator: mismatch");
      $finish;
    end
  end

  // Wait drawn per request or pixel; none during steady stretches
  function automatic int pick_wait();
    if (steady) return 0;
    return $urandom_range(0, 11);
  endfunction

  function automatic line_req_t make_line(input int sx, input int sy, input int ex, input int ey,
                                          input int col);
    line_req_t r;
    r.start_x     = coord_t'(sx);
    r.start_y     = coord_t'(sy);
    r.end_x       = coord_t'(ex);
    r.end_y       = coord_t'(ey);
    r.pixel_color = color_t'(col);
    return r;
  endfunction

  // Random line: half free endpoints, the rest points, axis lines and short hops
  function automatic line_req_t random_line();
    line_req_t r;
    int        kind;
    r = make_line($urandom, $urandom, $urandom, $urandom, $urandom);
    kind = $urandom_range(0, 19);
    if (kind < 3) begin
      r.end_x = r.start_x;
      r.end_y = r.start_y;
    end else if (kind < 5) begin
      r.end_x = r.start_x;
    end else if (kind < 7) begin
      r.end_y = r.start_y;
    end else if (kind < 10) begin
      r.end_x = coord_t'(r.start_x + $urandom_range(0, 6) - 3);
      r.end_y = coord_t'(r.start_y + $urandom_range(0, 6) - 3);
    end
    return r;
  endfunction

  // Offer one request and hold it until the block takes it
  task automatic send_line(input line_req_t req);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  // Pixel sink: random stalls, plus two long hold-offs to back the block up
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (sunk_pixels == 200 || sunk_pixels == 2000) stall = LONG_HOLD;
      else stall = pick_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sunk_pixels++;
    end
  end

  // Reset, requests and verdict
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    out_ready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // equal endpoints at both corners
    send_line(make_line(0, 0, 0, 0, 16'h0000));
    send_line(make_line(63, 63, 63, 63, 16'hFFFF));
    // full-length axis lines both ways
    send_line(make_line(0, 0, 63, 0, 16'hAAAA));
    send_line(make_line(63, 0, 0, 0, 16'h5555));
    send_line(make_line(0, 0, 0, 63, 16'hF800));
    send_line(make_line(0, 63, 0, 0, 16'h07E0));
    // diagonals across the whole field
    send_line(make_line(0, 0, 63, 63, 16'h001F));
    send_line(make_line(63, 63, 0, 0, 16'hFFFF));
    send_line(make_line(0, 63, 63, 0, 16'h8001));
    send_line(make_line(63, 0, 0, 63, 16'h7FFE));
    // one line into each octant from the center
    send_line(make_line(32, 32, 40, 35, 16'h1234));
    send_line(make_line(32, 32, 35, 40, 16'h2345));
    send_line(make_line(32, 32, 24, 35, 16'h3456));
    send_line(make_line(32, 32, 29, 40, 16'h4567));
    send_line(make_line(32, 32, 24, 29, 16'h5678));
    send_line(make_line(32, 32, 29, 24, 16'h6789));
    send_line(make_line(32, 32, 40, 29, 16'h789A));
    send_line(make_line(32, 32, 35, 24, 16'h89AB));
    // short hops, a near-diagonal and a near-vertical extreme
    send_line(make_line(10, 10, 11, 12, 16'hC0DE));
    send_line(make_line(5, 5, 6, 5, 16'h0001));
    send_line(make_line(0, 0, 63, 62, 16'h8000));
    send_line(make_line(1, 0, 0, 63, 16'hBEEF));

    for (int i = 0; i < RANDOM_LINES; i++) begin
      steady = ((i / 25) % 3 == 2);
      send_line(random_line());
    end
    steady = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);

    while (pending_pixels != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("line_pixel_generator: match");
    else
      $display("line_pixel_generator: mismatch");
    $finish;
  end

endmodule
